// ===== hw/rtl/rbes_pkg.sv =====
// ----------------------------------------------------------------------------
// rbes_pkg
// Shared types, constants and fixed-point helpers of the rigid body stepper.
// ----------------------------------------------------------------------------
package rbes_pkg;

    localparam int FRAC_BITS = 16;
    localparam int DT_W      = FRAC_BITS + 1;  // dt = 2^FRAC_BITS / tps
    localparam int QW        = 48;             // divider magnitude width
    localparam int DEN_W     = 31;             // divisor width

    localparam logic FUNC_LOAD = 1'b0;
    localparam logic FUNC_TICK = 1'b1;

    localparam logic [1:0] CFG_TICKS_PER_SEC = 2'd0;
    localparam logic [1:0] CFG_GRAVITY_X     = 2'd1;
    localparam logic [1:0] CFG_GRAVITY_Y     = 2'd2;
    localparam logic [1:0] CFG_PART_COUNT    = 2'd3;

    typedef struct packed {
        logic               func;
        logic [3:0]         part_index;
        logic [30:0]        mass;
        logic [30:0]        inertia;
        logic [30:0]        linear_drag;
        logic [30:0]        angular_drag;
        logic signed [31:0] center_x;
        logic signed [31:0] center_y;
    } t_in;

    typedef struct packed {
        logic [3:0]         out_index;
        logic signed [31:0] pos_x;
        logic signed [31:0] pos_y;
        logic signed [31:0] heading;
        logic signed [31:0] vel_x;
        logic signed [31:0] vel_y;
        logic signed [31:0] spin;
        logic               last;
    } t_out;

    typedef struct packed {
        logic signed [31:0] pos_x;
        logic signed [31:0] pos_y;
        logic signed [31:0] angle;
        logic signed [31:0] vel_x;
        logic signed [31:0] vel_y;
        logic signed [31:0] spin;
        logic [30:0]        mass;
        logic [30:0]        inertia;
        logic [30:0]        drag;
        logic [30:0]        adrag;
    } t_part;

    function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
        if (v > 64'sd2147483647) begin
            return 32'sh7FFFFFFF;
        end
        if (v < -64'sd2147483648) begin
            return 32'sh80000000;
        end
        return signed'(v[31:0]);
    endfunction

    // floor scaling of a product back to the fixed-point grid
    function automatic logic signed [63:0] fshift(input logic signed [63:0] v);
        return v >>> FRAC_BITS;
    endfunction

endpackage

// ===== hw/rtl/rigid_body_euler_step.sv =====
// ----------------------------------------------------------------------------
// rigid_body_euler_step
// Forward-Euler stepper for a table of planar rigid parts held in RAM.
// ----------------------------------------------------------------------------
// A load transaction writes one part in the cycle it is taken and leaves busy
// low. A tick with a nonzero part count first divides 2^16 by ticks_per_sec
// (launch, then the 48 quotient bits, then done), then walks the parts in
// index order: RAM read, eleven products through one shared 33x33
// multiplier, three quotients on the serial divider, then write-back. The
// serial divider dominates the time of a tick. Each result strobes on
// o_strobe the cycle after its write-back and cannot be held off.
// Configuration is always ready.
module rigid_body_euler_step #(
    parameter int MAX_PARTS = 16
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              start,
    output logic              busy,
    input  rbes_pkg::t_in     i_in,
    output logic              o_strobe,
    output rbes_pkg::t_out    o_res,
    input  logic              i_cfg_valid,
    output logic              o_cfg_ready,
    input  logic [1:0]        i_cfg_index,
    input  logic [31:0]       i_cfg_data
);

    localparam int AW = (MAX_PARTS > 1) ? $clog2(MAX_PARTS) : 1;
    localparam int CW = $clog2(MAX_PARTS + 1);
    localparam int QW = rbes_pkg::QW;
    localparam int DT_W = rbes_pkg::DT_W;

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_DTGO = 3'd1;
    localparam logic [2:0] ST_DT   = 3'd2;
    localparam logic [2:0] ST_RD   = 3'd3;
    localparam logic [2:0] ST_MUL  = 3'd4;
    localparam logic [2:0] ST_DVGO = 3'd5;
    localparam logic [2:0] ST_DV   = 3'd6;
    localparam logic [2:0] ST_WB   = 3'd7;

    // multiplier steps
    localparam logic [3:0] MS_GX_M  = 4'd0;
    localparam logic [3:0] MS_D_VX  = 4'd1;
    localparam logic [3:0] MS_GY_M  = 4'd2;
    localparam logic [3:0] MS_D_VY  = 4'd3;
    localparam logic [3:0] MS_AD_W  = 4'd4;
    localparam logic [3:0] MS_DT_VX = 4'd5;
    localparam logic [3:0] MS_DT_VY = 4'd6;
    localparam logic [3:0] MS_DT_W  = 4'd7;
    localparam logic [3:0] MS_DT_FX = 4'd8;
    localparam logic [3:0] MS_DT_FY = 4'd9;
    localparam logic [3:0] MS_DT_MO = 4'd10;
    localparam logic [3:0] MS_END   = 4'd11;
    localparam logic [3:0] MS_NONE  = 4'd15;

    localparam logic [1:0] DS_VX = 2'd0;
    localparam logic [1:0] DS_VY = 2'd1;
    localparam logic [1:0] DS_W  = 2'd2;

    logic [9:0]         r_tps;
    logic signed [31:0] r_gx;
    logic signed [31:0] r_gy;
    logic [4:0]         r_pc;

    logic [2:0]         r_state;
    logic [2:0]         n_state;
    logic [CW-1:0]      r_idx;
    logic [CW-1:0]      r_cnt;
    logic [3:0]         r_step;
    logic [3:0]         r_ptag;
    logic [1:0]         r_dsel;
    logic [DT_W-1:0]    r_dt;
    logic signed [63:0] r_prod;
    logic signed [63:0] r_t;
    logic signed [31:0] r_fx, r_fy, r_mo;
    logic signed [31:0] r_px, r_py, r_pa;
    logic signed [QW:0] r_nx, r_ny, r_nm;
    logic signed [QW:0] r_qx, r_qy, r_qw;
    rbes_pkg::t_out     r_res;
    logic               r_strobe;

    logic               acc;
    logic               ld_ok;
    logic [CW-1:0]      cnt_eff;
    logic [9:0]         tps_eff;
    logic               last_part;

    rbes_pkg::t_part    rd;
    rbes_pkg::t_part    wr_data;
    logic               wr_en;
    logic [AW-1:0]      wr_addr;

    logic signed [32:0] mul_a, mul_b;
    logic signed [65:0] mul_full;
    logic signed [63:0] fs;

    logic               div_start;
    logic signed [QW:0] div_num;
    logic [rbes_pkg::DEN_W-1:0] div_den;
    logic               div_busy;
    logic               div_done;
    logic signed [QW:0] div_quo;

    assign acc       = start && !busy;
    assign ld_ok     = (int'(i_in.part_index) < MAX_PARTS);
    assign cnt_eff   = (int'(r_pc) > MAX_PARTS) ? CW'(MAX_PARTS) : CW'(r_pc);
    assign tps_eff   = (r_tps == '0) ? 10'd1 : r_tps;
    assign last_part = (CW'(r_idx + 1'b1) == r_cnt);
    assign busy      = (r_state != ST_IDLE);
    assign o_cfg_ready = 1'b1;
    assign o_strobe  = r_strobe;
    assign o_res     = r_res;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tps <= 10'd60;
            r_gx  <= '0;
            r_gy  <= '0;
            r_pc  <= 5'd16;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                rbes_pkg::CFG_TICKS_PER_SEC: r_tps <= i_cfg_data[9:0];
                rbes_pkg::CFG_GRAVITY_X:     r_gx  <= signed'(i_cfg_data);
                rbes_pkg::CFG_GRAVITY_Y:     r_gy  <= signed'(i_cfg_data);
                rbes_pkg::CFG_PART_COUNT:    r_pc  <= i_cfg_data[4:0];
                default: ;
            endcase
        end
    end

    rbes_mem #(
        .DEPTH (MAX_PARTS),
        .AW    (AW)
    ) u_mem (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_rd_en   (r_state == ST_RD),
        .i_rd_addr (r_idx[AW-1:0]),
        .o_rd_data (rd),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_data)
    );

    // write port: a load in its accept cycle, or the write-back of a tick
    always_comb begin
        wr_en   = 1'b0;
        wr_addr = r_idx[AW-1:0];
        wr_data = rd;
        if (r_state == ST_WB) begin
            wr_en         = 1'b1;
            wr_data.pos_x = r_px;
            wr_data.pos_y = r_py;
            wr_data.angle = r_pa;
            wr_data.vel_x = rbes_pkg::sat32(64'(rd.vel_x) + 64'(r_qx));
            wr_data.vel_y = rbes_pkg::sat32(64'(rd.vel_y) + 64'(r_qy));
            wr_data.spin  = rbes_pkg::sat32(64'(rd.spin) + 64'(r_qw));
        end else if (acc && i_in.func == rbes_pkg::FUNC_LOAD) begin
            wr_en           = ld_ok;
            wr_addr         = AW'(i_in.part_index);
            wr_data.pos_x   = i_in.center_x;
            wr_data.pos_y   = i_in.center_y;
            wr_data.angle   = '0;
            wr_data.vel_x   = '0;
            wr_data.vel_y   = '0;
            wr_data.spin    = '0;
            wr_data.mass    = i_in.mass;
            wr_data.inertia = i_in.inertia;
            wr_data.drag    = i_in.linear_drag;
            wr_data.adrag   = i_in.angular_drag;
        end
    end

    // shared multiplier operand select
    always_comb begin
        mul_a = 33'(r_gx);
        mul_b = signed'({2'b00, rd.mass});
        case (r_step)
            MS_GX_M: begin
                mul_a = 33'(r_gx);
                mul_b = signed'({2'b00, rd.mass});
            end
            MS_D_VX: begin
                mul_a = signed'({2'b00, rd.drag});
                mul_b = 33'(rd.vel_x);
            end
            MS_GY_M: begin
                mul_a = 33'(r_gy);
                mul_b = signed'({2'b00, rd.mass});
            end
            MS_D_VY: begin
                mul_a = signed'({2'b00, rd.drag});
                mul_b = 33'(rd.vel_y);
            end
            MS_AD_W: begin
                mul_a = signed'({2'b00, rd.adrag});
                mul_b = 33'(rd.spin);
            end
            MS_DT_VX: begin
                mul_a = signed'(33'(r_dt));
                mul_b = 33'(rd.vel_x);
            end
            MS_DT_VY: begin
                mul_a = signed'(33'(r_dt));
                mul_b = 33'(rd.vel_y);
            end
            MS_DT_W: begin
                mul_a = signed'(33'(r_dt));
                mul_b = 33'(rd.spin);
            end
            MS_DT_FX: begin
                mul_a = signed'(33'(r_dt));
                mul_b = 33'(r_fx);
            end
            MS_DT_FY: begin
                mul_a = signed'(33'(r_dt));
                mul_b = 33'(r_fy);
            end
            MS_DT_MO: begin
                mul_a = signed'(33'(r_dt));
                mul_b = 33'(r_mo);
            end
            default: ;
        endcase
    end

    assign mul_full = mul_a * mul_b;
    assign fs       = rbes_pkg::fshift(r_prod);

    // divider operand select
    always_comb begin
        div_num = signed'((QW + 1)'(1 << rbes_pkg::FRAC_BITS));
        div_den = rbes_pkg::DEN_W'(tps_eff);
        if (r_state == ST_DVGO) begin
            case (r_dsel)
                DS_VX: begin
                    div_num = r_nx;
                    div_den = rd.mass;
                end
                DS_VY: begin
                    div_num = r_ny;
                    div_den = rd.mass;
                end
                default: begin
                    div_num = r_nm;
                    div_den = rd.inertia;
                end
            endcase
        end
    end

    assign div_start = (r_state == ST_DTGO) || (r_state == ST_DVGO);

    rbes_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num   (div_num),
        .i_den   (div_den),
        .o_busy  (div_busy),
        .o_done  (div_done),
        .o_quo   (div_quo)
    );

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (acc && i_in.func == rbes_pkg::FUNC_TICK && cnt_eff != '0) begin
                    n_state = ST_DTGO;
                end
            end
            ST_DTGO: n_state = ST_DT;
            ST_DT:   n_state = div_done ? ST_RD : ST_DT;
            ST_RD:   n_state = ST_MUL;
            ST_MUL:  n_state = (r_step == MS_END) ? ST_DVGO : ST_MUL;
            ST_DVGO: n_state = ST_DV;
            ST_DV: begin
                if (div_done) begin
                    n_state = (r_dsel == DS_W) ? ST_WB : ST_DVGO;
                end
            end
            ST_WB:   n_state = last_part ? ST_IDLE : ST_RD;
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_idx    <= '0;
            r_cnt    <= '0;
            r_step   <= '0;
            r_ptag   <= MS_NONE;
            r_dsel   <= '0;
            r_strobe <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_strobe <= (r_state == ST_WB);
            r_ptag   <= (r_state == ST_MUL && r_step < MS_END) ? r_step : MS_NONE;
            case (r_state)
                ST_IDLE: begin
                    r_idx <= '0;
                    r_cnt <= cnt_eff;
                end
                ST_RD:   r_step <= '0;
                ST_MUL:  r_step <= r_step + 1'b1;
                ST_DV: begin
                    if (div_done) begin
                        r_dsel <= r_dsel + 1'b1;
                    end
                end
                ST_WB: begin
                    r_dsel <= DS_VX;
                    r_idx  <= r_idx + 1'b1;
                end
                default: ;
            endcase
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        if (r_state == ST_DT && div_done) begin
            r_dt <= DT_W'(div_quo);
        end
        if (r_state == ST_MUL) begin
            r_prod <= signed'(mul_full[63:0]);
        end
        case (r_ptag)
            MS_GX_M:  r_t  <= fs;
            MS_D_VX:  r_fx <= rbes_pkg::sat32(r_t - fs);
            MS_GY_M:  r_t  <= fs;
            MS_D_VY:  r_fy <= rbes_pkg::sat32(r_t - fs);
            MS_AD_W:  r_mo <= rbes_pkg::sat32(-fs);
            MS_DT_VX: r_px <= rbes_pkg::sat32(64'(rd.pos_x) + fs);
            MS_DT_VY: r_py <= rbes_pkg::sat32(64'(rd.pos_y) + fs);
            MS_DT_W:  r_pa <= rbes_pkg::sat32(64'(rd.angle) + fs);
            MS_DT_FX: r_nx <= signed'(r_prod[QW:0]);
            MS_DT_FY: r_ny <= signed'(r_prod[QW:0]);
            MS_DT_MO: r_nm <= signed'(r_prod[QW:0]);
            default: ;
        endcase
        if (r_state == ST_DV && div_done) begin
            case (r_dsel)
                DS_VX:   r_qx <= div_quo;
                DS_VY:   r_qy <= div_quo;
                default: r_qw <= div_quo;
            endcase
        end
        if (r_state == ST_WB) begin
            r_res.out_index <= 4'(r_idx);
            r_res.pos_x     <= wr_data.pos_x;
            r_res.pos_y     <= wr_data.pos_y;
            r_res.heading   <= wr_data.angle;
            r_res.vel_x     <= wr_data.vel_x;
            r_res.vel_y     <= wr_data.vel_y;
            r_res.spin      <= wr_data.spin;
            r_res.last      <= last_part;
        end
    end

    a_last_frees: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && o_res.last) |-> !busy)
        else $error("busy still high after final result of a tick");

    a_div_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |-> !div_busy)
        else $error("divider busy while a new transaction is taken");

    a_tick_entry: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(busy) |-> (r_state == ST_DTGO))
        else $error("tick did not begin with the time step division");

endmodule

// ===== hw/rtl/rbes_mem.sv =====
// ----------------------------------------------------------------------------
// rbes_mem
// Part table: one synchronous RAM entry per part, registered read, with
// per-entry valid bits so the motion state of an unwritten slot reads zero.
// ----------------------------------------------------------------------------
module rbes_mem #(
    parameter int DEPTH = 16,
    parameter int AW    = 4
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_rd_en,
    input  logic [AW-1:0]        i_rd_addr,
    output rbes_pkg::t_part      o_rd_data,
    input  logic                 i_wr_en,
    input  logic [AW-1:0]        i_wr_addr,
    input  rbes_pkg::t_part      i_wr_data
);

    rbes_pkg::t_part mem [DEPTH];
    logic [DEPTH-1:0] r_valid;
    rbes_pkg::t_part  r_rd_data;
    logic             r_rd_valid;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= mem[i_rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid    <= '0;
            r_rd_valid <= 1'b0;
        end else begin
            if (i_wr_en) begin
                r_valid[i_wr_addr] <= 1'b1;
            end
            if (i_rd_en) begin
                r_rd_valid <= r_valid[i_rd_addr];
            end
        end
    end

    always_comb begin
        o_rd_data = r_rd_data;
        if (!r_rd_valid) begin
            o_rd_data.pos_x = '0;
            o_rd_data.pos_y = '0;
            o_rd_data.angle = '0;
            o_rd_data.vel_x = '0;
            o_rd_data.vel_y = '0;
            o_rd_data.spin  = '0;
        end
    end

endmodule

// ===== hw/rtl/rbes_div.sv =====
// ----------------------------------------------------------------------------
// rbes_div
// Serial restoring divider, one quotient bit per cycle, signed numerator,
// unsigned divisor, quotient truncated toward zero, zero for a zero divisor.
// ----------------------------------------------------------------------------
module rbes_div (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_start,
    input  logic signed [rbes_pkg::QW:0]      i_num,
    input  logic [rbes_pkg::DEN_W-1:0]        i_den,
    output logic                              o_busy,
    output logic                              o_done,
    output logic signed [rbes_pkg::QW:0]      o_quo
);

    localparam int QW  = rbes_pkg::QW;
    localparam int DW  = rbes_pkg::DEN_W;
    localparam int CNW = $clog2(QW + 1);

    logic           r_busy;
    logic           r_done;
    logic [CNW-1:0] r_cnt;
    logic [QW-1:0]  r_quo;
    logic [DW-1:0]  r_rem;
    logic [DW-1:0]  r_den;
    logic           r_neg;
    logic           r_zero;

    logic [DW:0]    rem_sh;
    logic           n_bit;
    logic [DW-1:0]  n_rem;
    logic [QW-1:0]  mag;

    assign mag    = QW'(i_num[QW] ? -i_num : i_num);
    assign rem_sh = {r_rem, r_quo[QW-1]};
    assign n_bit  = rem_sh >= {1'b0, r_den};
    assign n_rem  = n_bit ? DW'(rem_sh - {1'b0, r_den}) : DW'(rem_sh);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNW'(QW);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CNW'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quo  <= mag;
            r_rem  <= '0;
            r_den  <= i_den;
            r_neg  <= i_num[QW];
            r_zero <= (i_den == '0);
        end else if (r_busy) begin
            r_rem <= n_rem;
            r_quo <= {r_quo[QW-2:0], n_bit};
        end
    end

    always_comb begin
        if (r_zero) begin
            o_quo = '0;
        end else if (r_neg) begin
            o_quo = -signed'({1'b0, r_quo});
        end else begin
            o_quo = signed'({1'b0, r_quo});
        end
    end

    assign o_busy = r_busy;
    assign o_done = r_done;

endmodule
